>>> src/cftp_pkg.sv
// Package for the cheapest feasible task picker.
// Holds table sizing, field widths, payload structs, status and state codes.
// No dependencies; every other file of the block imports it.
package cftp_pkg;

    // Table sizing
    localparam int TASK_SLOTS = 64;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

    // Field widths
    localparam int ID_W       = 16;
    localparam int COORD_W    = 10;
    localparam int PATH_W     = 16;
    localparam int WP_W       = 8;
    localparam int CHARGE_W   = 19;
    localparam int BIAS_W     = 10;
    localparam int RESERVE_W  = 16;
    localparam int ARR_W      = 32;
    localparam int DSUM_W     = 17;
    localparam int PROD_W     = WP_W + BIAS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_BIAS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_RESERVE = 1'd1;

    // Request kinds
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_AGENT = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_ASSIGNED = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_REQ_SCAN,
        S_REQ_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               req_type;
        logic [ID_W-1:0]    task_id;
        logic [COORD_W-1:0] task_start_x;
        logic [COORD_W-1:0] task_start_y;
        logic [PATH_W-1:0]  task_path_length;
        logic [WP_W-1:0]    task_waypoint_count;
        logic [ID_W-1:0]    agent_id;
        logic [COORD_W-1:0] agent_x;
        logic [COORD_W-1:0] agent_y;
        logic [CHARGE_W-1:0] agent_charge;
    } t_in;

    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     chosen_task_id;
        logic [ID_W-1:0]     served_agent_id;
        logic [CHARGE_W-1:0] chosen_cost;
    } t_out;

    // One table entry as kept in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]    task_id;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [PATH_W-1:0]  path_length;
        logic [WP_W-1:0]    waypoint_count;
        logic [ARR_W-1:0]   arrival;
    } t_slot;

endpackage

>>> src/cheapest_feasible_task_picker_unit.sv
// Top level of the cheapest feasible task picker: slot memory, valid bits,
// scan pipeline and control sequencer.
// Depends on cftp_pkg.
//
// Sequence: an add item scans up from slot 0 to the lowest free slot, or goes
//   straight to its result when the table is full; an agent request reads the
//   slot memory one slot per cycle into its three-stage cost pipeline.
// Throughput: one item at a time; the next item is taken once the current
//   result sits in the output register.
// Reset (sync, active low) clears the valid bits, count, arrival counter,
//   config registers and control; slot memory contents stay undefined.
module cheapest_feasible_task_picker_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cftp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cftp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  cftp_pkg::t_in                     i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output cftp_pkg::t_out                    o_out_data,
    input  logic                              i_out_stall
);
    import cftp_pkg::*;

    t_state                r_state, n_state;
    t_in                   r_item;
    logic [BIAS_W-1:0]     r_bias;
    logic [RESERVE_W-1:0]  r_reserve;
    logic [TASK_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]      r_count;
    logic [ARR_W-1:0]      r_arrival;
    logic [IDX_W-1:0]      r_idx, n_idx;

    // Slot memory
    t_slot                 r_mem [TASK_SLOTS];
    t_slot                 r_rd_data;

    // Scan pipeline
    logic                  r_p0_vld, r_p0_sv;
    logic [IDX_W-1:0]      r_p0_idx;
    logic                  r_p1_vld, r_p1_sv;
    logic [IDX_W-1:0]      r_p1_idx;
    logic [DSUM_W-1:0]     r_p1_dsum;
    logic [PROD_W-1:0]     r_p1_prod;
    logic [ARR_W-1:0]      r_p1_age;
    logic [ID_W-1:0]       r_p1_id;
    logic                  r_p2_vld, r_p2_sv;
    logic [IDX_W-1:0]      r_p2_idx;
    logic [CHARGE_W-1:0]   r_p2_cost;
    logic [ARR_W-1:0]      r_p2_age;
    logic [ID_W-1:0]       r_p2_id;

    // Running best
    logic                  r_best_found;
    logic [IDX_W-1:0]      r_best_idx;
    logic [CHARGE_W-1:0]   r_best_cost;
    logic [ARR_W-1:0]      r_best_age;
    logic [ID_W-1:0]       r_best_id;

    // Result and output register
    t_out                  r_res, n_res;
    logic                  r_out_valid;
    t_out                  r_out_data;

    // Control decode
    logic                  in_accept, table_full, cur_free, last_idx, pipe_busy, out_free;
    logic                  add_write, scan_issue, finish_req, load_out;
    logic [COORD_W-1:0]    dx, dy;
    logic                  better;

    assign table_full = (r_count == CNT_W'(TASK_SLOTS));
    assign cur_free   = !r_valid[r_idx];
    assign last_idx   = (r_idx == IDX_W'(TASK_SLOTS - 1));
    assign pipe_busy  = r_p0_vld || r_p1_vld || r_p2_vld;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.req_type == REQ_AGENT) begin
                        n_state = S_REQ_SCAN;
                    end else if (table_full) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ADD_SCAN;
                    end
                end
            end
            S_ADD_SCAN: begin
                if (cur_free) n_state = S_DONE;
            end
            S_REQ_SCAN: begin
                if (last_idx) n_state = S_REQ_DRAIN;
            end
            S_REQ_DRAIN: begin
                if (!pipe_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        in_accept  = 1'b0;
        add_write  = 1'b0;
        scan_issue = 1'b0;
        finish_req = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                in_accept  = i_in_valid;
            end
            S_ADD_SCAN:  add_write  = cur_free;
            S_REQ_SCAN:  scan_issue = 1'b1;
            S_REQ_DRAIN: finish_req = !pipe_busy;
            S_DONE:      load_out   = out_free;
            default: ;
        endcase
    end

    // Scan index and result word
    always_comb begin
        n_idx = r_idx;
        n_res = r_res;
        if (in_accept) begin
            n_idx = '0;
            n_res = '{status: ST_FULL, chosen_task_id: '0, served_agent_id: '0,
                      chosen_cost: '0};
        end else if (r_state == S_ADD_SCAN) begin
            if (!cur_free) n_idx = r_idx + 1'b1;
            n_res = '{status: ST_STORED, chosen_task_id: '0, served_agent_id: '0,
                      chosen_cost: '0};
        end else if (scan_issue) begin
            n_idx = r_idx + 1'b1;
        end else if (finish_req) begin
            if (r_best_found) begin
                n_res = '{status: ST_ASSIGNED, chosen_task_id: r_best_id,
                          served_agent_id: r_item.agent_id, chosen_cost: r_best_cost};
            end else begin
                n_res = '{status: ST_NONE, chosen_task_id: '0,
                          served_agent_id: r_item.agent_id, chosen_cost: '0};
            end
        end
    end

    // Distance terms of the entry just read
    assign dx = (r_item.agent_x > r_rd_data.start_x) ? r_item.agent_x - r_rd_data.start_x
                                                      : r_rd_data.start_x - r_item.agent_x;
    assign dy = (r_item.agent_y > r_rd_data.start_y) ? r_item.agent_y - r_rd_data.start_y
                                                      : r_rd_data.start_y - r_item.agent_y;

    // Feasible and cheaper, or equal cost and older
    assign better = r_p2_vld && r_p2_sv && (r_p2_cost <= r_item.agent_charge) &&
                    (!r_best_found || (r_p2_cost < r_best_cost) ||
                     ((r_p2_cost == r_best_cost) && (r_p2_age > r_best_age)));

    // Slot memory: write on add, read one slot per cycle on scan
    always_ff @(posedge i_clk) begin
        if (add_write) begin
            r_mem[r_idx] <= '{task_id: r_item.task_id, start_x: r_item.task_start_x,
                              start_y: r_item.task_start_y,
                              path_length: r_item.task_path_length,
                              waypoint_count: r_item.task_waypoint_count,
                              arrival: r_arrival};
        end
        r_rd_data <= r_mem[r_idx];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) r_item <= i_in_data;
        r_res <= n_res;
        r_idx <= n_idx;
        // stage 0: tag of the read in flight
        r_p0_idx <= r_idx;
        r_p0_sv  <= r_valid[r_idx];
        // stage 1: partial sums, product, age
        r_p1_idx  <= r_p0_idx;
        r_p1_sv   <= r_p0_sv;
        r_p1_dsum <= DSUM_W'(dx) + DSUM_W'(dy) + DSUM_W'(r_rd_data.path_length);
        r_p1_prod <= PROD_W'(r_rd_data.waypoint_count) * PROD_W'(r_bias);
        r_p1_age  <= r_arrival - r_rd_data.arrival;
        r_p1_id   <= r_rd_data.task_id;
        // stage 2: full cost
        r_p2_idx  <= r_p1_idx;
        r_p2_sv   <= r_p1_sv;
        r_p2_cost <= CHARGE_W'(r_p1_dsum) + CHARGE_W'(r_p1_prod) + CHARGE_W'(r_reserve);
        r_p2_age  <= r_p1_age;
        r_p2_id   <= r_p1_id;
        // stage 3: keep the best candidate
        if (better) begin
            r_best_idx  <= r_p2_idx;
            r_best_cost <= r_p2_cost;
            r_best_age  <= r_p2_age;
            r_best_id   <= r_p2_id;
        end
        if (load_out) r_out_data <= r_res;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bias       <= '0;
            r_reserve    <= '0;
            r_valid      <= '0;
            r_count      <= '0;
            r_arrival    <= '0;
            r_p0_vld     <= 1'b0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p0_vld <= scan_issue;
            r_p1_vld <= r_p0_vld;
            r_p2_vld <= r_p1_vld;
            // take config writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WAYPOINT_BIAS:  r_bias    <= i_cfg_data[BIAS_W-1:0];
                    CFG_CHARGE_RESERVE: r_reserve <= i_cfg_data[RESERVE_W-1:0];
                    default: ;
                endcase
            end
            // occupy a slot on add
            if (add_write) begin
                r_valid[r_idx] <= 1'b1;
                r_count        <= r_count + 1'b1;
                r_arrival      <= r_arrival + 1'b1;
            end
            // free the chosen slot
            if (finish_req && r_best_found) begin
                r_valid[r_best_idx] <= 1'b0;
                r_count             <= r_count - 1'b1;
            end
            // best tracking
            if (in_accept) begin
                r_best_found <= 1'b0;
            end else if (better) begin
                r_best_found <= 1'b1;
            end
            // output beat
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> src/cftp_checker.sv
// Port checker for the cheapest feasible task picker, with its bind.
// Depends on cftp_pkg and cheapest_feasible_task_picker_unit.
module cftp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input cftp_pkg::t_out                    o_out_data,
    input logic                              i_out_stall
);
    import cftp_pkg::*;

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed under stall");

    // Busy after taking an item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the item finished");

    // Add results carry no task, agent or cost
    a_add_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_STORED || o_out_data.status == ST_FULL)
        |-> o_out_data.chosen_task_id == '0 && o_out_data.served_agent_id == '0 &&
            o_out_data.chosen_cost == '0)
        else $error("add result with nonzero fields");

    // No feasible task means no task and no cost
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_NONE
        |-> o_out_data.chosen_task_id == '0 && o_out_data.chosen_cost == '0)
        else $error("no-task result with nonzero task or cost");

endmodule

bind cheapest_feasible_task_picker_unit cftp_checker u_cftp_checker (.*);

>>> bench/cheapest_feasible_task_picker_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for cheapest_feasible_task_picker_unit: queued task and agent beats
// are checked against an in-bench model of the task table and its cost rule.
// Depends on cftp_pkg and the unit RTL.
module cheapest_feasible_task_picker_unit_test;
    import cftp_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 80;
    localparam int unsigned CHARGE_MAX = (1 << CHARGE_W) - 1;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  i_out_stall = 1'b0;

    // Bench copy of the task table and cost settings
    logic             tbl_used [TASK_SLOTS];
    t_slot            tbl      [TASK_SLOTS];
    logic [ARR_W-1:0] stamp_next = '0;
    int unsigned      cur_bias    = 0;
    int unsigned      cur_reserve = 0;

    t_in  offer_q   [$];
    t_out outcome_q [$];
    t_in  last_geo = '0;

    logic in_beat       = 1'b0;
    int   send_idle_pct = 8;
    int   recv_idle_pct = 80;
    int   hold_req      = 0;
    int   hold_seen     = 0;
    int   hold_left     = 0;
    int   miss_count    = 0;
    int   items_sent    = 0;
    int   n_stored = 0, n_assigned = 0, n_none = 0, n_full = 0;

    cheapest_feasible_task_picker_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            tbl_used[i] = 1'b0;
        end
    end

    // Store a task or pick the cheapest feasible one, updating the bench table
    function automatic t_out pick_outcome(t_in item);
        t_out             res;
        int               slot;
        int unsigned      ax, ay, sx, sy, dx, dy, cost, best_cost;
        logic [ARR_W-1:0] age, best_age;
        res = '0;
        slot = -1;
        if (item.req_type == REQ_ADD) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (!tbl_used[i] && slot < 0) slot = i;
            end
            if (slot < 0) begin
                res.status = ST_FULL;
            end else begin
                tbl_used[slot]            = 1'b1;
                tbl[slot].task_id         = item.task_id;
                tbl[slot].start_x         = item.task_start_x;
                tbl[slot].start_y         = item.task_start_y;
                tbl[slot].path_length     = item.task_path_length;
                tbl[slot].waypoint_count  = item.task_waypoint_count;
                tbl[slot].arrival         = stamp_next;
                stamp_next                = stamp_next + 1;
                res.status                = ST_STORED;
            end
        end else begin
            res.served_agent_id = item.agent_id;
            ax = 32'(item.agent_x);
            ay = 32'(item.agent_y);
            best_cost = 0;
            best_age = '0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (tbl_used[i]) begin
                    sx = 32'(tbl[i].start_x);
                    sy = 32'(tbl[i].start_y);
                    dx = (ax > sx) ? ax - sx : sx - ax;
                    dy = (ay > sy) ? ay - sy : sy - ay;
                    cost = dx + dy + 32'(tbl[i].path_length)
                         + 32'(tbl[i].waypoint_count) * cur_bias + cur_reserve;
                    age = stamp_next - tbl[i].arrival;
                    if (cost <= 32'(item.agent_charge) &&
                        (slot < 0 || cost < best_cost ||
                         (cost == best_cost && age > best_age))) begin
                        slot = i;
                        best_cost = cost;
                        best_age = age;
                    end
                end
            end
            if (slot < 0) begin
                res.status = ST_NONE;
            end else begin
                res.status         = ST_ASSIGNED;
                res.chosen_task_id = tbl[slot].task_id;
                res.chosen_cost    = best_cost[CHARGE_W-1:0];
                tbl_used[slot]     = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic log_miss(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        miss_count++;
    endtask

    // Compare one output beat with the oldest outcome waiting
    task automatic check_result(t_out got);
        t_out want;
        if (outcome_q.size() == 0) begin
            log_miss($sformatf("result with nothing pending: status %0d id %h agent %h cost %0d",
                               got.status, got.chosen_task_id, got.served_agent_id,
                               got.chosen_cost));
            return;
        end
        want = outcome_q.pop_front();
        case (want.status)
            ST_STORED:   n_stored++;
            ST_ASSIGNED: n_assigned++;
            ST_NONE:     n_none++;
            default:     n_full++;
        endcase
        if (got.status !== want.status)
            log_miss($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.chosen_task_id !== want.chosen_task_id)
            log_miss($sformatf("chosen_task_id %h, want %h",
                               got.chosen_task_id, want.chosen_task_id));
        if (got.served_agent_id !== want.served_agent_id)
            log_miss($sformatf("served_agent_id %h, want %h",
                               got.served_agent_id, want.served_agent_id));
        if (got.chosen_cost !== want.chosen_cost)
            log_miss($sformatf("chosen_cost %0d, want %0d", got.chosen_cost, want.chosen_cost));
    endtask

    // Monitor: check output beats, predict accepted input beats
    always @(posedge i_clk) begin
        in_beat <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (i_in_valid && !o_in_stall) outcome_q = {outcome_q, pick_outcome(i_in_data)};
        end
    end

    // Driver: hold a stalled beat, otherwise offer the next one or idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beat)) begin
            if (offer_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= offer_q.pop_front();
                i_in_valid <= 1'b1;
                items_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Mostly extremes and small values, the rest anywhere in range
    function automatic int unsigned spread(int unsigned hi);
        case ($urandom_range(7))
            0:       return 0;
            1:       return hi;
            2, 3:    return $urandom_range(hi >> 4);
            default: return $urandom_range(hi);
        endcase
    endfunction

    function automatic t_in noise_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_in)-1:0];
    endfunction

    // Append one beat to the driver queue
    task automatic queue_item(t_in item);
        offer_q = {offer_q, item};
    endtask

    task automatic queue_add(logic [ID_W-1:0] id, int unsigned x, int unsigned y,
                             int unsigned path, int unsigned wp);
        t_in item;
        item = noise_item();
        item.req_type            = REQ_ADD;
        item.task_id             = id;
        item.task_start_x        = COORD_W'(x);
        item.task_start_y        = COORD_W'(y);
        item.task_path_length    = PATH_W'(path);
        item.task_waypoint_count = WP_W'(wp);
        queue_item(item);
    endtask

    task automatic queue_ask(logic [ID_W-1:0] agent, int unsigned x, int unsigned y,
                             int unsigned charge);
        t_in item;
        item = noise_item();
        item.req_type     = REQ_AGENT;
        item.agent_id     = agent;
        item.agent_x      = COORD_W'(x);
        item.agent_y      = COORD_W'(y);
        item.agent_charge = CHARGE_W'(charge);
        queue_item(item);
    endtask

    // Random mix of adds and requests; add_pct steers the table fill level
    task automatic queue_random(int count, int add_pct);
        t_in         item;
        int unsigned span;
        for (int n = 0; n < count; n++) begin
            item = noise_item();
            if ($urandom_range(99) < add_pct) begin
                item.req_type = REQ_ADD;
                if ($urandom_range(7) == 0) begin
                    // reuse the previous geometry to provoke cost ties
                    item.task_start_x        = last_geo.task_start_x;
                    item.task_start_y        = last_geo.task_start_y;
                    item.task_path_length    = last_geo.task_path_length;
                    item.task_waypoint_count = last_geo.task_waypoint_count;
                end else begin
                    if ($urandom_range(1)) begin
                        item.task_start_x = COORD_W'(spread(1023));
                        item.task_start_y = COORD_W'(spread(1023));
                    end else begin
                        item.task_start_x = COORD_W'($urandom_range(540, 480));
                        item.task_start_y = COORD_W'($urandom_range(540, 480));
                    end
                    item.task_path_length = PATH_W'($urandom_range(1) ? $urandom_range(3000)
                                                                      : spread(65535));
                    item.task_waypoint_count = WP_W'(($urandom_range(3) == 0)
                                                     ? spread(255) : $urandom_range(8, 1));
                end
                last_geo = item;
            end else begin
                item.req_type = REQ_AGENT;
                if ($urandom_range(1)) begin
                    item.agent_x = COORD_W'(spread(1023));
                    item.agent_y = COORD_W'(spread(1023));
                end else begin
                    item.agent_x = COORD_W'($urandom_range(540, 480));
                    item.agent_y = COORD_W'($urandom_range(540, 480));
                end
                case ($urandom_range(7))
                    0: item.agent_charge = CHARGE_W'(CHARGE_MAX);
                    1: item.agent_charge = CHARGE_W'($urandom_range(cur_reserve));
                    default: begin
                        span = cur_reserve + $urandom_range(6000)
                             + cur_bias * $urandom_range(8);
                        item.agent_charge = CHARGE_W'((span > CHARGE_MAX) ? CHARGE_MAX : span);
                    end
                endcase
            end
            queue_item(item);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_WAYPOINT_BIAS) cur_bias = 32'(data[BIAS_W-1:0]);
        else cur_reserve = 32'(data);
    endtask

    // Bias travels with junk in the upper data bits, which the block must drop
    task automatic set_costs(int unsigned bias, int unsigned reserve);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[BIAS_W-1:0] = BIAS_W'(bias);
        write_reg(CFG_WAYPOINT_BIAS, word);
        write_reg(CFG_CHARGE_RESERVE, CFG_DATA_W'(reserve));
    endtask

    // Wait until every queued beat has gone in and every result has come out
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
            #1;
        end while (offer_q.size() != 0 || i_in_valid || outcome_q.size() != 0);
        repeat (4) @(negedge i_clk);
        #1;
    endtask

    initial begin : main
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset costs: empty table, extreme tasks, zero waypoints, exact fit, ties
        queue_ask(16'h1234, 5, 5, 100);
        queue_add(16'hFFFF, 1023, 1023, 65535, 255);
        queue_add(16'h0000, 0, 0, 0, 0);
        queue_ask(16'h0000, 0, 0, 0);
        queue_ask(16'hFFFF, 0, 0, 67580);
        queue_ask(16'hA5A5, 0, 0, 67581);
        queue_add(16'h0A00, 100, 200, 50, 3);
        queue_add(16'h0B00, 100, 200, 50, 3);
        queue_add(16'h0C00, 110, 200, 40, 3);
        queue_ask(16'h0001, 100, 200, CHARGE_MAX);
        queue_ask(16'h0002, 100, 200, CHARGE_MAX);
        queue_ask(16'h0003, 100, 200, CHARGE_MAX);
        queue_ask(16'h0004, 100, 200, CHARGE_MAX);
        wait_idle();

        // Largest bias and reserve: widest cost, one short of it, exact fit
        set_costs(1023, 65535);
        queue_add(16'h5A5A, 0, 1023, 65535, 255);
        queue_ask(16'h0010, 1023, 0, 393980);
        queue_ask(16'h0011, 1023, 0, CHARGE_MAX);
        queue_add(16'h1111, 512, 512, 0, 1);
        queue_ask(16'h0012, 512, 512, 66558);
        wait_idle();

        // Random, sender mostly busy, receiver mostly stalled
        set_costs($urandom_range(20, 1), $urandom_range(300));
        queue_random(170, 60);
        wait_idle();

        // Random, add-heavy so the table fills; sender mostly idle
        send_idle_pct = 80;
        recv_idle_pct = 8;
        set_costs($urandom_range(1023), $urandom_range(65535));
        queue_random(170, 85);
        wait_idle();

        // Random, request-heavy so the table drains; no idling, one long hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_costs(0, 0);
        queue_random(170, 25);
        hold_req++;
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outcome_q.size() != 0)
            log_miss($sformatf("%0d results never arrived", outcome_q.size()));

        $display("Covered %0d beats: %0d stored, %0d table full, %0d assigned, %0d unfit",
                 items_sent, n_stored, n_full, n_assigned, n_none);
        $display("Five cost settings incl. both extremes, three idle mixes, %0d mismatches",
                 miss_count);
        if (miss_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
